// ----- src/lcdns_pkg.sv -----
// Shared types, request codes and timing constants for the LCD nibble sequencer.
// No dependencies.
package lcdns_pkg;

    localparam int WAIT_W = 17;
    localparam int STEP_W = 4;

    // Request codes on the func field
    typedef enum logic [2:0] {
        FUNC_INIT     = 3'd0,
        FUNC_COMMAND  = 3'd1,
        FUNC_DATA     = 3'd2,
        FUNC_CLEAR    = 3'd3,
        FUNC_DISPLAY  = 3'd4,
        FUNC_POSITION = 3'd5
    } t_func;

    // Waits in microseconds
    localparam logic [WAIT_W-1:0] WAIT_NONE  = 17'd0;
    localparam logic [WAIT_W-1:0] WAIT_CMD   = 17'd50;
    localparam logic [WAIT_W-1:0] WAIT_SHORT = 17'd120;
    localparam logic [WAIT_W-1:0] WAIT_CLEAR = 17'd2000;
    localparam logic [WAIT_W-1:0] WAIT_BOOT  = 17'd5000;
    localparam logic [WAIT_W-1:0] WAIT_POWER = 17'd20000;
    localparam logic [WAIT_W-1:0] WAIT_LONG  = 17'd120000;

    // Step numbers of the two transfer runs
    localparam logic [STEP_W-1:0] STEP_FIRST     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_BYTE_LAST = 4'd1;
    localparam logic [STEP_W-1:0] STEP_INIT_LAST = 4'd14;

    // Classified request, as queued between front and back
    typedef struct packed {
        logic       is_init;
        logic       reg_select;
        logic [7:0] data_byte;
        logic       clear_wait;
    } t_desc;

    // One nibble transfer on the LCD bus
    typedef struct packed {
        logic              strobe;
        logic              reg_select;
        logic [3:0]        nibble;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } t_xfer;

    // Init run: step 0 is the power-up wait, steps 1..14 the nibbles
    function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
        logic [3:0] nib;
        case (step)
            4'd1, 4'd2, 4'd3:                   nib = 4'h3;
            4'd4, 4'd5:                         nib = 4'h2;
            4'd6, 4'd8:                         nib = 4'h8;
            4'd10:                              nib = 4'h1;
            4'd12:                              nib = 4'h6;
            4'd14:                              nib = 4'hC;
            default:                            nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic logic [WAIT_W-1:0] init_wait(input logic [STEP_W-1:0] step);
        logic [WAIT_W-1:0] w;
        case (step)
            4'd0:                   w = WAIT_POWER;
            4'd1:                   w = WAIT_BOOT;
            4'd2, 4'd3:             w = WAIT_SHORT;
            4'd4:                   w = WAIT_LONG;
            4'd6, 4'd8, 4'd12, 4'd14: w = WAIT_CMD;
            4'd10:                  w = WAIT_CLEAR;
            default:                w = WAIT_NONE;
        endcase
        return w;
    endfunction

endpackage

// ----- src/char_lcd_nibble_sequencer_core.sv -----
// Top level of the LCD nibble sequencer: front end, descriptor queue, back end.
// Depends on lcdns_pkg, lcdns_front, lcdns_queue, lcdns_back.
//
// Turns requests for a 4-bit character LCD into nibble transfers, one word
// per request on the push side and one word per transfer on the pop side.
// A request is taken whenever the descriptor queue has room
// (QUEUE_DEPTH entries), so bursts are absorbed at one per cycle. The back
// end emits one transfer per cycle into its output register while the
// consumer pops: a byte request (command, data, clear, display control,
// position) expands into 2 transfers, the initialization into 15; that expansion
// sets the sustained rate. Unknown func codes are taken and produce nothing.
module char_lcd_nibble_sequencer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [2:0]                      i_func,
    input  logic [7:0]                      i_value,
    input  logic [1:0]                      i_row,
    input  logic [7:0]                      i_column,
    input  logic                            i_display_on,
    input  logic                            i_cursor_on,
    input  logic                            i_blink_on,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_strobe_res,
    output logic                            o_reg_select,
    output logic [3:0]                      o_nibble,
    output logic [lcdns_pkg::WAIT_W-1:0]    o_wait_us,
    output logic                            o_last
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    lcdns_pkg::t_desc q_wr_data;
    lcdns_pkg::t_desc q_rd_data;

    lcdns_front u_front (
        .push         (push),
        .full         (full),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_display_on (i_display_on),
        .i_cursor_on  (i_cursor_on),
        .i_blink_on   (i_blink_on),
        .o_q_push     (q_push),
        .o_q_data     (q_wr_data),
        .i_q_full     (q_full)
    );

    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    lcdns_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_data     (q_rd_data),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_strobe_res (o_strobe_res),
        .o_reg_select (o_reg_select),
        .o_nibble     (o_nibble),
        .o_wait_us    (o_wait_us),
        .o_last       (o_last)
    );

endmodule

// ----- src/lcdns_front.sv -----
// Front end: accepts requests and classifies them into queue descriptors.
// Depends on lcdns_pkg.
module lcdns_front (
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           i_func,
    input  logic [7:0]           i_value,
    input  logic [1:0]           i_row,
    input  logic [7:0]           i_column,
    input  logic                 i_display_on,
    input  logic                 i_cursor_on,
    input  logic                 i_blink_on,
    output logic                 o_q_push,
    output lcdns_pkg::t_desc     o_q_data,
    input  logic                 i_q_full
);

    logic [7:0] line_base;
    logic       known;

    // Line base addresses of the four display rows
    always_comb begin
        case (i_row)
            2'd0:    line_base = 8'd128;
            2'd1:    line_base = 8'd192;
            2'd2:    line_base = 8'd148;
            default: line_base = 8'd212;
        endcase
    end

    // Classify request into a descriptor
    always_comb begin
        known               = 1'b1;
        o_q_data.is_init    = 1'b0;
        o_q_data.reg_select = 1'b0;
        o_q_data.data_byte  = i_value;
        o_q_data.clear_wait = 1'b0;
        case (i_func)
            lcdns_pkg::FUNC_INIT: begin
                o_q_data.is_init = 1'b1;
            end
            lcdns_pkg::FUNC_COMMAND: begin
                o_q_data.data_byte = i_value;
            end
            lcdns_pkg::FUNC_DATA: begin
                o_q_data.reg_select = 1'b1;
            end
            lcdns_pkg::FUNC_CLEAR: begin
                o_q_data.data_byte  = 8'h01;
                o_q_data.clear_wait = 1'b1;
            end
            lcdns_pkg::FUNC_DISPLAY: begin
                o_q_data.data_byte = {5'b00001, i_display_on, i_cursor_on, i_blink_on};
            end
            lcdns_pkg::FUNC_POSITION: begin
                o_q_data.data_byte = line_base + i_column;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Unknown codes are taken and dropped
    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full && known;

endmodule

// ----- src/lcdns_queue.sv -----
// Short descriptor queue between the front and back ends.
// Depends on lcdns_pkg.
module lcdns_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lcdns_pkg::t_desc i_data,
    output logic             o_full,
    input  logic             i_pop,
    output lcdns_pkg::t_desc o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lcdns_pkg::t_desc r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- src/lcdns_back.sv -----
// Back end: expands queued descriptors into nibble transfers, one per cycle
// when its output register is empty or popped. Depends on lcdns_pkg.
module lcdns_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lcdns_pkg::t_desc                i_q_data,
    input  logic                            i_q_empty,
    output logic                            o_q_pop,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_strobe_res,
    output logic                            o_reg_select,
    output logic [3:0]                      o_nibble,
    output logic [lcdns_pkg::WAIT_W-1:0]    o_wait_us,
    output logic                            o_last
);

    logic [lcdns_pkg::STEP_W-1:0] r_step, n_step;
    logic                         r_valid;
    lcdns_pkg::t_xfer             r_out, n_out;
    logic                         advance;
    logic                         produce;

    assign advance = !r_valid || pop;
    assign produce = advance && !i_q_empty;

    // Transfer for the current step of the head descriptor
    always_comb begin
        n_out.reg_select = i_q_data.reg_select;
        if (i_q_data.is_init) begin
            n_out.strobe     = (r_step != lcdns_pkg::STEP_FIRST);
            n_out.reg_select = 1'b0;
            n_out.nibble     = lcdns_pkg::init_nibble(r_step);
            n_out.wait_us    = lcdns_pkg::init_wait(r_step);
            n_out.last       = (r_step == lcdns_pkg::STEP_INIT_LAST);
        end else begin
            n_out.strobe = 1'b1;
            if (r_step == lcdns_pkg::STEP_FIRST) begin
                n_out.nibble  = i_q_data.data_byte[7:4];
                n_out.wait_us = lcdns_pkg::WAIT_NONE;
                n_out.last    = 1'b0;
            end else begin
                n_out.nibble  = i_q_data.data_byte[3:0];
                n_out.wait_us = i_q_data.clear_wait ? lcdns_pkg::WAIT_CLEAR
                                                    : lcdns_pkg::WAIT_CMD;
                n_out.last    = 1'b1;
            end
        end
    end

    // Step counter: restart and release the descriptor after its last transfer
    always_comb begin
        n_step  = r_step;
        o_q_pop = 1'b0;
        if (produce) begin
            if (n_out.last) begin
                n_step  = lcdns_pkg::STEP_FIRST;
                o_q_pop = 1'b1;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= lcdns_pkg::STEP_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (advance) begin
                r_valid <= !i_q_empty;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out <= n_out;
        end
    end

    assign empty        = !r_valid;
    assign o_strobe_res = r_out.strobe;
    assign o_reg_select = r_out.reg_select;
    assign o_nibble     = r_out.nibble;
    assign o_wait_us    = r_out.wait_us;
    assign o_last       = r_out.last;

    // Step stays inside the init run
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= lcdns_pkg::STEP_INIT_LAST)
        else $error("step counter beyond init run");

    // A byte descriptor never sees more than two steps
    a_byte_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_q_empty && !i_q_data.is_init) |-> (r_step <= lcdns_pkg::STEP_BYTE_LAST))
        else $error("byte descriptor past its second nibble");

    // Last transfer produced restarts the step counter
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (produce && n_out.last) |=> (r_step == lcdns_pkg::STEP_FIRST))
        else $error("step counter not restarted after last transfer");

    // Descriptor released only together with its last transfer
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_valid && r_out.last))
        else $error("descriptor released without last transfer");

endmodule
